// ----- rtl/jetc_pkg.sv -----
// Shared constants, palette table and helper functions for the Julia pixel colourer.
`default_nettype none

package jetc_pkg;

  // Default elaboration values
  localparam int unsigned JETC_COORD_BITS      = 10;
  localparam int unsigned JETC_FRAC_BITS       = 28;
  localparam int unsigned JETC_PALETTE_ENTRIES = 17;

  // Configuration register indexes
  localparam int unsigned REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_C_REAL      = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_C_IMAG      = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_X_MIN       = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_Y_MIN       = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_X_STEP      = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_Y_STEP      = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_ITER_LIMIT  = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_ESC_RAD_SQ  = 3'd7;

  // Register reset values
  localparam logic signed [31:0] RST_C_REAL     = 32'sd103620113;
  localparam logic signed [31:0] RST_C_IMAG     = 32'sd37784438;
  localparam logic signed [31:0] RST_X_MIN      = -32'sd402653184;
  localparam logic signed [31:0] RST_Y_MIN      = -32'sd402653184;
  localparam logic [30:0]        RST_X_STEP     = 31'd894785;
  localparam logic [30:0]        RST_Y_STEP     = 31'd1150438;
  localparam logic [15:0]        RST_ITER_LIMIT = 16'd1000;
  localparam logic [30:0]        RST_ESC_RAD_SQ = 31'd1073741824;

  // Built-in colour table, {red, green, blue}
  localparam int unsigned PAL_TABLE_SIZE = 17;
  localparam logic [23:0] PAL_TABLE [PAL_TABLE_SIZE] = '{
    24'h421E0F, 24'h19071A, 24'h09012F, 24'h040449,
    24'h000764, 24'h0C2C8A, 24'h1852B1, 24'h397DD1,
    24'h86B5E5, 24'hD3ECF8, 24'hF1E9BF, 24'hF8C95F,
    24'hFFAA00, 24'hCC8000, 24'h995700, 24'h6A3403,
    24'h421E0F
  };

  // Entries past the built-in table read as black
  function automatic logic [23:0] pal_lookup(logic [7:0] idx);
    logic [23:0] rgb;
    rgb = 24'h000000;
    if (idx < 8'(PAL_TABLE_SIZE)) begin
      rgb = PAL_TABLE[idx[4:0]];
    end
    return rgb;
  endfunction

  // floor((a + 3*b) / 4)
  function automatic logic [7:0] blend(logic [7:0] a, logic [7:0] b);
    logic [9:0] sum;
    sum = {2'b00, a} + {2'b00, b} + {1'b0, b, 1'b0};
    return sum[9:2];
  endfunction

  // Clamp a 64-bit signed value to the signed 32-bit range
  function automatic logic signed [31:0] sat32(logic signed [63:0] v);
    logic signed [31:0] r;
    if ((v[63:31] == {33{1'b0}}) || (v[63:31] == {33{1'b1}})) begin
      r = v[31:0];
    end else if (v[63]) begin
      r = 32'sh8000_0000;
    end else begin
      r = 32'sh7FFF_FFFF;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/julia_escape_time_pixel_colorer.sv -----
// Julia set escape-time pixel colourer: start point, shared-multiplier iteration, palette blend.
// The palette step holds while a finished word still waits in the output register, and a new
//   pixel is taken only once the sequencer is back in idle.
// Each iteration makes three passes through the single 32x32 signed multiplier (zr*zr, zi*zi,
//   zr*zi), then updates z.
// Reset (rst_ni low, asynchronous): sequencer idle, output empty, configuration registers back to
//   their defaults (c = 0.386+0.141i, view corner -1.5-1.5i, iteration limit 1000, escape bound 4.0).
`default_nettype none

module julia_escape_time_pixel_colorer
  import jetc_pkg::*;
#(
  parameter int unsigned COORD_BITS      = JETC_COORD_BITS,
  parameter int unsigned FRAC_BITS       = JETC_FRAC_BITS,
  parameter int unsigned PALETTE_ENTRIES = JETC_PALETTE_ENTRIES
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // configuration write channel
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [REG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [31:0]           cfg_data_i,
  // pixel input channel
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [COORD_BITS-1:0] pixel_x_i,
  input  wire logic [COORD_BITS-1:0] pixel_y_i,
  // colour output channel
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic [7:0]                 red_o,
  output logic [7:0]                 green_o,
  output logic [7:0]                 blue_o,
  output logic [15:0]                iteration_count_o
);

  localparam int unsigned PAL_IDX_W = (PALETTE_ENTRIES > 2) ? $clog2(PALETTE_ENTRIES - 1) : 1;
  localparam logic [PAL_IDX_W-1:0] PAL_IDX_LAST = PAL_IDX_W'(PALETTE_ENTRIES - 2);

  // Sequencer codes
  localparam logic [3:0] S_IDLE = 4'd0; // wait for a pixel
  localparam logic [3:0] S_INX  = 4'd1; // multiply px * x_step
  localparam logic [3:0] S_INY  = 4'd2; // multiply py * y_step, load zr
  localparam logic [3:0] S_ZI   = 4'd3; // load zi, multiply zr * zr
  localparam logic [3:0] S_RR   = 4'd4; // multiply zr * zr
  localparam logic [3:0] S_II   = 4'd5; // hold zr^2, multiply zi * zi
  localparam logic [3:0] S_RI   = 4'd6; // escape test, multiply zr * zi
  localparam logic [3:0] S_UPD  = 4'd7; // write new z, advance the counters
  localparam logic [3:0] S_PAL  = 4'd8; // blend palette into the output register

  // Configuration registers
  logic signed [31:0] c_real_q, c_imag_q, x_min_q, y_min_q;
  logic [30:0]        x_step_q, y_step_q, esc_q;
  logic [15:0]        iter_limit_q;

  // Datapath
  logic [3:0]              state_q, state_d;
  logic [COORD_BITS-1:0]   px_q, py_q;
  logic signed [31:0]      zr_q, zr_d, zi_q, zi_d;
  logic signed [31:0]      mul_a, mul_b;
  logic signed [63:0]      prod_q;
  logic signed [63:0]      rr_q, diff_q;
  logic [15:0]             iter_q;
  logic [PAL_IDX_W-1:0]    pal_idx_q;
  logic [63:0]             mag;
  logic [63:0]             bound;
  logic                    stop;
  logic signed [63:0]      re_sum, im_sum, x0_sum, y0_sum;
  logic [7:0]              idx_a, idx_b;
  logic [23:0]             rgb_a, rgb_b;
  logic                    out_free;
  logic                    in_acc;

  // Output register
  logic       out_valid_q;
  logic [7:0] red_q, green_q, blue_q;
  logic [15:0] count_q;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_real_q     <= RST_C_REAL;
      c_imag_q     <= RST_C_IMAG;
      x_min_q      <= RST_X_MIN;
      y_min_q      <= RST_Y_MIN;
      x_step_q     <= RST_X_STEP;
      y_step_q     <= RST_Y_STEP;
      iter_limit_q <= RST_ITER_LIMIT;
      esc_q        <= RST_ESC_RAD_SQ;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_C_REAL:     c_real_q     <= cfg_data_i;
        REG_C_IMAG:     c_imag_q     <= cfg_data_i;
        REG_X_MIN:      x_min_q      <= cfg_data_i;
        REG_Y_MIN:      y_min_q      <= cfg_data_i;
        REG_X_STEP:     x_step_q     <= cfg_data_i[30:0];
        REG_Y_STEP:     y_step_q     <= cfg_data_i[30:0];
        REG_ITER_LIMIT: iter_limit_q <= cfg_data_i[15:0];
        REG_ESC_RAD_SQ: esc_q        <= cfg_data_i[30:0];
      endcase
    end
  end

  // Operand select for the one shared multiplier
  always_comb begin
    unique case (state_q)
      S_INX: begin
        mul_a = 32'({{(32 - COORD_BITS){1'b0}}, px_q});
        mul_b = {1'b0, x_step_q};
      end
      S_INY: begin
        mul_a = 32'({{(32 - COORD_BITS){1'b0}}, py_q});
        mul_b = {1'b0, y_step_q};
      end
      S_ZI, S_RR: begin
        mul_a = zr_q;
        mul_b = zr_q;
      end
      S_II: begin
        mul_a = zi_q;
        mul_b = zi_q;
      end
      S_RI: begin
        mul_a = zr_q;
        mul_b = zi_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
  end

  // Start point: offset plus scaled pixel index, clamped to 32 bits
  assign x0_sum = {{32{x_min_q[31]}}, x_min_q} + prod_q;
  assign y0_sum = {{32{y_min_q[31]}}, y_min_q} + prod_q;

  // Escape test: |z|^2 against the bound at 64 bits, zi*zi arriving from the multiplier
  assign mag   = 64'(rr_q) + 64'(prod_q);
  assign bound = {{33{1'b0}}, esc_q} << FRAC_BITS;
  assign stop  = (iter_q >= iter_limit_q) || (mag >= bound);

  // z*z + c, floored shifts back to the fixed-point grid; keep every operand signed
  assign re_sum = (diff_q >>> FRAC_BITS) + $signed({{32{c_real_q[31]}}, c_real_q});
  assign im_sum = (prod_q >>> (FRAC_BITS - 1)) + $signed({{32{c_imag_q[31]}}, c_imag_q});

  always_comb begin
    state_d = state_q;
    zr_d    = zr_q;
    zi_d    = zi_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = S_INX;
        end
      end
      S_INX: state_d = S_INY;
      S_INY: begin
        zr_d    = sat32(x0_sum);
        state_d = S_ZI;
      end
      S_ZI: begin
        zi_d    = sat32(y0_sum);
        state_d = S_II;
      end
      S_RR: state_d = S_II;
      S_II: state_d = S_RI;
      S_RI: state_d = stop ? S_PAL : S_UPD;
      S_UPD: begin
        zr_d    = sat32(re_sum);
        zi_d    = sat32(im_sum);
        state_d = S_RR;
      end
      S_PAL: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Iteration state; the palette index runs alongside the count so no modulo is needed
  always_ff @(posedge clk_i) begin
    zr_q <= zr_d;
    zi_q <= zi_d;
    if (in_acc) begin
      px_q      <= pixel_x_i;
      py_q      <= pixel_y_i;
      iter_q    <= '0;
      pal_idx_q <= '0;
    end
    if (state_q == S_II) begin
      rr_q <= prod_q;
    end
    if (state_q == S_RI) begin
      diff_q <= rr_q - prod_q;
    end
    if (state_q == S_UPD) begin
      iter_q    <= iter_q + 16'd1;
      pal_idx_q <= (pal_idx_q == PAL_IDX_LAST) ? '0 : pal_idx_q + PAL_IDX_W'(1);
    end
  end

  // Palette entries i and i+1
  assign idx_a = 8'(pal_idx_q);
  assign idx_b = idx_a + 8'd1;
  assign rgb_a = pal_lookup(idx_a);
  assign rgb_b = pal_lookup(idx_b);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((state_q == S_PAL) && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == S_PAL) && out_free) begin
      red_q   <= blend(rgb_a[23:16], rgb_b[23:16]);
      green_q <= blend(rgb_a[15:8],  rgb_b[15:8]);
      blue_q  <= blend(rgb_a[7:0],   rgb_b[7:0]);
      count_q <= iter_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign red_o             = red_q;
  assign green_o           = green_q;
  assign blue_o            = blue_q;
  assign iteration_count_o = count_q;

  // Checks
  a_upd_below_limit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_UPD) |-> (iter_q < iter_limit_q))
    else $error("iteration update past the limit");

  a_pal_idx_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_UPD) |-> (pal_idx_q <= PAL_IDX_LAST))
    else $error("palette index out of range");

  a_pal_waits : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PAL && out_valid_q && out_stall_i) |=> (state_q == S_PAL))
    else $error("finished word dropped while output stalled");

  a_accept_starts : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == S_INX))
    else $error("accepted pixel did not start the sequencer");

endmodule

`default_nettype wire

// ----- tb/julia_colour_check.sv -----
`timescale 1ns / 1ps
// Colour checker: predicts escape count and blended colour per pixel and checks the output words.
module julia_colour_check
  import jetc_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_i,
  input  logic [REG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]          cfg_data_i,
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  logic [9:0]           pixel_x_i,
  input  logic [9:0]           pixel_y_i,
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  logic [7:0]           red_i,
  input  logic [7:0]           green_i,
  input  logic [7:0]           blue_i,
  input  logic [15:0]          iteration_count_i,
  output int                   pending_o,
  output int                   fail_count_o
);

  localparam int unsigned Q_FRAC      = 28;
  localparam int unsigned RAMP_PERIOD = 16;
  localparam longint      S32_MAX     = 64'sd2147483647;
  localparam longint      S32_MIN     = -64'sd2147483648;
  localparam int          REPORT_MAX  = 10;

  // {red, green, blue}; the last entry repeats the first so the blend wraps
  localparam logic [23:0] COLOUR_RAMP [17] = '{
    24'h421E0F, 24'h19071A, 24'h09012F, 24'h040449,
    24'h000764, 24'h0C2C8A, 24'h1852B1, 24'h397DD1,
    24'h86B5E5, 24'hD3ECF8, 24'hF1E9BF, 24'hF8C95F,
    24'hFFAA00, 24'hCC8000, 24'h995700, 24'h6A3403,
    24'h421E0F
  };

  typedef struct packed {
    logic [9:0]  px;
    logic [9:0]  py;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [15:0] iters;
  } pixel_colour_t;

  pixel_colour_t expected_colours[$];
  pixel_colour_t want;

  logic signed [31:0] julia_cr, julia_ci, view_x0, view_y0;
  logic [30:0]        col_step, row_step, esc_bound;
  logic [15:0]        iter_limit;

  function automatic longint clamp32(longint v);
    if (v > S32_MAX) return S32_MAX;
    if (v < S32_MIN) return S32_MIN;
    return v;
  endfunction

  function automatic logic [7:0] mix_channel(logic [7:0] a, logic [7:0] b);
    return 8'((int'(a) + 3 * int'(b)) >> 2);
  endfunction

  function automatic pixel_colour_t colour_of_pixel(logic [9:0] px, logic [9:0] py);
    longint          zr, zi, rr, ii, ri;
    longint unsigned mag, limit_mag;
    int unsigned     n;
    logic [23:0]     lo, hi;
    pixel_colour_t   w;
    zr = clamp32(longint'(julia_cr) * 0 + longint'(view_x0)
                 + longint'({54'd0, px}) * longint'({33'd0, col_step}));
    zi = clamp32(longint'(view_y0) + longint'({54'd0, py}) * longint'({33'd0, row_step}));
    limit_mag = {33'd0, esc_bound} << Q_FRAC;
    n = 0;
    while (n < iter_limit) begin
      rr  = zr * zr;
      ii  = zi * zi;
      ri  = zr * zi;
      mag = rr + ii;
      if (mag >= limit_mag) break;
      zr = clamp32(((rr - ii) >>> Q_FRAC) + longint'(julia_cr));
      zi = clamp32((ri >>> (Q_FRAC - 1)) + longint'(julia_ci));
      n++;
    end
    lo = COLOUR_RAMP[n % RAMP_PERIOD];
    hi = COLOUR_RAMP[n % RAMP_PERIOD + 1];
    w.px    = px;
    w.py    = py;
    w.red   = mix_channel(lo[23:16], hi[23:16]);
    w.green = mix_channel(lo[15:8], hi[15:8]);
    w.blue  = mix_channel(lo[7:0], hi[7:0]);
    w.iters = 16'(n);
    return w;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      julia_cr   = 32'sd103620113;
      julia_ci   = 32'sd37784438;
      view_x0    = -32'sd402653184;
      view_y0    = -32'sd402653184;
      col_step   = 31'd894785;
      row_step   = 31'd1150438;
      iter_limit = 16'd1000;
      esc_bound  = 31'd1073741824;
      expected_colours.delete();
      pending_o    = 0;
      fail_count_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_C_REAL:     julia_cr   = cfg_data_i;
          REG_C_IMAG:     julia_ci   = cfg_data_i;
          REG_X_MIN:      view_x0    = cfg_data_i;
          REG_Y_MIN:      view_y0    = cfg_data_i;
          REG_X_STEP:     col_step   = cfg_data_i[30:0];
          REG_Y_STEP:     row_step   = cfg_data_i[30:0];
          REG_ITER_LIMIT: iter_limit = cfg_data_i[15:0];
          REG_ESC_RAD_SQ: esc_bound  = cfg_data_i[30:0];
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_colours.size() == 0) begin
          fail_count_o = fail_count_o + 1;
          if (fail_count_o <= REPORT_MAX)
            $display("colour check: word with nothing pending, rgb %0d,%0d,%0d n=%0d",
                     red_i, green_i, blue_i, iteration_count_i);
        end else begin
          want = expected_colours.pop_front();
          if (red_i !== want.red || green_i !== want.green || blue_i !== want.blue ||
              iteration_count_i !== want.iters) begin
            fail_count_o = fail_count_o + 1;
            if (fail_count_o <= REPORT_MAX)
              $display("colour check: pixel (%0d,%0d) expected rgb %0d,%0d,%0d n=%0d, got %0d,%0d,%0d n=%0d",
                       want.px, want.py, want.red, want.green, want.blue, want.iters,
                       red_i, green_i, blue_i, iteration_count_i);
          end
        end
      end
      if (in_valid_i && !in_stall_i)
        expected_colours.push_back(colour_of_pixel(pixel_x_i, pixel_y_i));
      pending_o = expected_colours.size();
    end
  end

endmodule

// ----- tb/tb_julia_escape_time_pixel_colorer.sv -----
`timescale 1ns / 1ps
// Testbench top: drives pixel and register traffic into the Julia colourer and gives the verdict.
module tb_julia_escape_time_pixel_colorer
  import jetc_pkg::*;
();

  // The slowest word is a pixel that never escapes at an iteration limit of 65535.
  // Allow a good margin over its run time before calling the run hung.
  localparam int unsigned WATCHDOG_LIMIT = 1000000;
  localparam int          PHASES         = 13;
  localparam int          PHASE_PIXELS   = 43;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [REG_IDX_W-1:0] cfg_index;
  logic [31:0]          cfg_data;
  logic                 in_valid;
  logic                 in_stall;
  logic [9:0]           pixel_x;
  logic [9:0]           pixel_y;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [7:0]           red;
  logic [7:0]           green;
  logic [7:0]           blue;
  logic [15:0]          iteration_count;

  int          pending;
  int          fail_count;
  bit          src_gaps;
  bit          sink_gaps;
  int          sink_wait;
  int unsigned idle_cycles = 0;

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  julia_escape_time_pixel_colorer dut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_o       (cfg_ready),
    .cfg_index_i       (cfg_index),
    .cfg_data_i        (cfg_data),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .pixel_x_i         (pixel_x),
    .pixel_y_i         (pixel_y),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .red_o             (red),
    .green_o           (green),
    .blue_o            (blue),
    .iteration_count_o (iteration_count)
  );

  julia_colour_check u_colour_check (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_i       (cfg_ready),
    .cfg_index_i       (cfg_index),
    .cfg_data_i        (cfg_data),
    .in_valid_i        (in_valid),
    .in_stall_i        (in_stall),
    .pixel_x_i         (pixel_x),
    .pixel_y_i         (pixel_y),
    .out_valid_i       (out_valid),
    .out_stall_i       (out_stall),
    .red_i             (red),
    .green_i           (green),
    .blue_i            (blue),
    .iteration_count_i (iteration_count),
    .pending_o         (pending),
    .fail_count_o      (fail_count)
  );

  // Colour sink: before each word raise stall at random (never when sink gaps are off),
  // then drop it and wait for the word to be taken.
  always begin
    @(negedge clk);
    sink_wait = sink_gaps ? $urandom_range(0, 3) : 0;
    if (sink_wait > 0) begin
      out_stall <= 1'b1;
      repeat (sink_wait) @(negedge clk);
    end
    out_stall <= 1'b0;
    @(posedge clk);
    while (!(out_valid && !out_stall)) @(posedge clk);
  end

  // Watchdog: count cycles in which no word moves on any channel.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // All driving tasks start and end just after a falling edge.

  // Write one register; lower valid before returning so a back-to-back write
  // never lowers and raises it in the same step.
  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic load_view(input logic [31:0] cr, input logic [31:0] ci,
                           input logic [31:0] x0, input logic [31:0] y0,
                           input logic [31:0] xs, input logic [31:0] ys,
                           input logic [31:0] iters, input logic [31:0] esc);
    write_reg(REG_C_REAL, cr);
    write_reg(REG_C_IMAG, ci);
    write_reg(REG_X_MIN, x0);
    write_reg(REG_Y_MIN, y0);
    write_reg(REG_X_STEP, xs);
    write_reg(REG_Y_STEP, ys);
    write_reg(REG_ITER_LIMIT, iters);
    write_reg(REG_ESC_RAD_SQ, esc);
  endtask

  // Offer one pixel word after an optional gap; valid stays high on return so the
  // next word can follow without a bubble.
  task automatic send_pixel(input logic [9:0] x, input logic [9:0] y);
    int gap;
    gap = src_gaps ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    pixel_x  <= x;
    pixel_y  <= y;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // Drop valid and hold off until every predicted colour word has come back, then
  // let the sequencer return to idle.
  task automatic settle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // Pick a fresh register setting: mostly a sensible view of the set with random c,
  // size and limit; now and then raw random words to exercise masking and saturation.
  task automatic random_view(input bit deep);
    logic [31:0] cr, ci, x0, y0, xs, ys, iters, esc;
    if ($urandom_range(0, 4) != 0) begin
      cr    = 32'($urandom_range(0, 402653184)) - 32'd268435456;
      ci    = 32'($urandom_range(0, 536870912)) - 32'd268435456;
      x0    = 32'd0 - 32'd402653184 - 32'($urandom_range(0, 67108864));
      y0    = 32'd0 - 32'd402653184 - 32'($urandom_range(0, 67108864));
      xs    = 32'd805306368 / $urandom_range(600, 1100);
      ys    = 32'd805306368 / $urandom_range(600, 1100);
      iters = deep ? 32'd1000 : 32'($urandom_range(1, 96));
      esc   = ($urandom_range(0, 3) != 0) ? 32'd1073741824 :
              32'($urandom_range(268435456, 2147483647));
    end else begin
      cr    = $urandom;
      ci    = $urandom;
      x0    = $urandom;
      y0    = $urandom;
      xs    = $urandom;
      ys    = $urandom;
      iters = 32'($urandom_range(0, 128));
      esc   = $urandom;
    end
    load_view(cr, ci, x0, y0, xs, ys, iters, esc);
  endtask

  initial begin
    rst_n     = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_C_REAL;
    cfg_data  = 32'd0;
    in_valid  = 1'b0;
    pixel_x   = 10'd0;
    pixel_y   = 10'd0;
    src_gaps  = 1'b0;
    sink_gaps = 1'b0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Reset view, no idling: corners and the middle of the image.
    send_pixel(10'd0, 10'd0);
    send_pixel(10'd1023, 10'd1023);
    send_pixel(10'd0, 10'd1023);
    send_pixel(10'd1023, 10'd0);
    send_pixel(10'd512, 10'd512);
    settle();

    // Start point out of range: left edge at the top of the range, top edge at the
    // bottom, steps at their widest; all but pixel (0,0) saturate, and all escape at once.
    src_gaps  = 1'b1;
    sink_gaps = 1'b1;
    load_view(32'd103620113, 32'd37784438, 32'h7FFF_FFFF, 32'h8000_0000,
              32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd1000, 32'h7FFF_FFFF);
    send_pixel(10'd1023, 10'd1023);
    send_pixel(10'd0, 10'd0);
    send_pixel(10'd1023, 10'd0);
    send_pixel(10'd0, 10'd1023);
    settle();

    // z leaving the range mid-iteration: c at both range ends, row 0 starting at 2.0 - 1.9i
    // inside the widest escape bound, so its first update saturates both parts.
    load_view(32'h7FFF_FFFF, 32'h8000_0000, 32'd536870912, -32'sd510027366,
              32'd0, 32'h0200_0000, 32'hFFFF, 32'h7FFF_FFFF);
    send_pixel(10'd0, 10'd0);
    send_pixel(10'd1023, 10'd0);
    send_pixel(10'd7, 10'd15);
    send_pixel(10'd1023, 10'd1023);
    settle();

    // Zero iteration limit, then a limit of one.
    sink_gaps = 1'b0;
    load_view(32'd103620113, 32'd37784438, -32'sd402653184, -32'sd402653184,
              32'd894785, 32'd1150438, 32'd0, 32'd1073741824);
    send_pixel(10'd0, 10'd0);
    send_pixel(10'd1023, 10'd511);
    settle();
    write_reg(REG_ITER_LIMIT, 32'd1);
    send_pixel(10'd512, 10'd512);
    send_pixel(10'd1, 10'd2);
    settle();

    // Zero escape bound: nothing is inside.
    write_reg(REG_ITER_LIMIT, 32'd1000);
    write_reg(REG_ESC_RAD_SQ, 32'd0);
    send_pixel(10'd512, 10'd512);
    send_pixel(10'd0, 10'd0);
    settle();

    // Fixed point at the origin with c = 0 and the largest limit: the count runs out.
    load_view(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'hFFFF, 32'd1);
    send_pixel(10'd0, 10'd0);
    settle();

    // Random phases, the middle one mostly at the default limit; at times drain mid-phase.
    for (int phase = 0; phase < PHASES; phase++) begin
      src_gaps  = ($urandom_range(0, 3) != 0);
      sink_gaps = ($urandom_range(0, 3) != 0);
      random_view(phase == PHASES / 2);
      for (int k = 0; k < PHASE_PIXELS; k++) begin
        send_pixel(10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)));
        if ($urandom_range(0, 39) == 0) settle();
      end
      settle();
    end

    repeat (16) @(negedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
